[src/bfhp_pkg.sv]
package bfhp_pkg;

  // Width of the byte offset counters.
  localparam int OFFSET_BITS = 24;
  localparam int PAYLOAD_BITS = 24;
  localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

  // Result codes.
  localparam logic [2:0] STATUS_OK_HEADER  = 3'd0;
  localparam logic [2:0] STATUS_OK_NO_HDR  = 3'd1;
  localparam logic [2:0] STATUS_TOO_SHORT  = 3'd2;
  localparam logic [2:0] STATUS_BAD_HEADER = 3'd3;
  localparam logic [2:0] STATUS_BAD_SYNC   = 3'd4;

  localparam logic [7:0] KEY_B = 8'h62;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } bfhp_in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [PAYLOAD_BITS-1:0] payload_start;
  } bfhp_out_t;

  // Bit-file preamble, bytes 0 to 13, ending in key 'a'.
  function automatic logic [7:0] pre_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h00;
      4'd1:    val = 8'h09;
      4'd2:    val = 8'h0F;
      4'd3:    val = 8'hF0;
      4'd4:    val = 8'h0F;
      4'd5:    val = 8'hF0;
      4'd6:    val = 8'h0F;
      4'd7:    val = 8'hF0;
      4'd8:    val = 8'h0F;
      4'd9:    val = 8'hF0;
      4'd10:   val = 8'h00;
      4'd11:   val = 8'h00;
      4'd12:   val = 8'h01;
      4'd13:   val = 8'h61;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Sync sequence FF FF FF FF AA 99 55 66.
  function automatic logic [7:0] sync_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd4:    val = 8'hAA;
      3'd5:    val = 8'h99;
      3'd6:    val = 8'h55;
      3'd7:    val = 8'h66;
      default: val = 8'hFF;
    endcase
    return val;
  endfunction

endpackage

[src/bfhp_parser.sv]
module bfhp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  bfhp_pkg::bfhp_in_t in_item,
  output logic               emit,
  output bfhp_pkg::bfhp_out_t result
);
  import bfhp_pkg::*;

  typedef enum logic [3:0] {
    PH_PRE, PH_NOHDR, PH_AKEY, PH_LENHI, PH_LENLO, PH_SKIP, PH_KEY, PH_SYNC, PH_DONE
  } phase_t;

  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] byte_count, byte_count_next;
  logic [15:0]            field_remaining, field_remaining_next;
  logic [2:0]             key_index, key_index_next;
  logic                   header_match, header_match_next;
  logic                   sync_match, sync_match_next;
  logic                   verdict_given, verdict_given_next;
  logic [OFFSET_BITS-1:0] sync_position, sync_position_next;

  logic [7:0]             b;
  logic                   pos_lt14, pos_lt8, pos_ge9, pos_ge13, pos_ge15;
  logic [15:0]            fr_dec;
  logic [2:0]             sync_idx;
  logic [2:0]             status;
  logic [PAYLOAD_BITS-1:0] start;

  assign b        = in_item.data_byte;
  assign pos_lt14 = byte_count < OFFSET_BITS'(14);
  assign pos_lt8  = byte_count < OFFSET_BITS'(8);
  assign pos_ge9  = byte_count >= OFFSET_BITS'(9);
  assign pos_ge13 = byte_count >= OFFSET_BITS'(13);
  assign pos_ge15 = byte_count >= OFFSET_BITS'(15);
  assign fr_dec   = (field_remaining != 16'd0) ? field_remaining - 16'd1 : 16'd0;
  assign sync_idx = field_remaining[2:0];

  always_comb begin
    phase_next           = phase;
    field_remaining_next = field_remaining;
    key_index_next       = key_index;
    header_match_next    = header_match;
    sync_match_next      = sync_match;
    verdict_given_next   = verdict_given;
    sync_position_next   = sync_position;
    emit                 = 1'b0;
    status               = STATUS_OK_HEADER;
    start                = '0;

    case (phase)
      PH_PRE: begin
        if (pos_lt14 && (b != pre_byte(byte_count[3:0]))) header_match_next = 1'b0;
        if (pos_lt8 && (b != sync_byte(byte_count[2:0]))) sync_match_next = 1'b0;
        if (pos_ge9) phase_next = header_match_next ? PH_AKEY : PH_NOHDR;
      end
      PH_NOHDR: begin
        if (pos_ge15) begin
          emit   = 1'b1;
          status = sync_match ? STATUS_OK_NO_HDR : STATUS_BAD_SYNC;
        end
      end
      PH_AKEY: begin
        if (pos_lt14 && (b != pre_byte(byte_count[3:0]))) header_match_next = 1'b0;
        if (pos_ge13) begin
          key_index_next = 3'd0;
          phase_next     = PH_LENHI;
        end
      end
      PH_LENHI: begin
        if (!header_match && pos_ge15) begin
          emit   = 1'b1;
          status = STATUS_BAD_HEADER;
        end else if (key_index >= 3'd4) begin
          field_remaining_next = 16'd3;
          phase_next           = PH_SKIP;
        end else begin
          field_remaining_next = {b, 8'h00};
          phase_next           = PH_LENLO;
        end
      end
      PH_LENLO: begin
        if (!header_match && pos_ge15) begin
          emit   = 1'b1;
          status = STATUS_BAD_HEADER;
        end else begin
          field_remaining_next = {field_remaining[15:8], field_remaining[7:0] | b};
          phase_next = (field_remaining_next != 16'd0) ? PH_SKIP : PH_KEY;
        end
      end
      PH_SKIP: begin
        field_remaining_next = fr_dec;
        if (fr_dec == 16'd0) begin
          if (key_index >= 3'd4) begin
            phase_next         = PH_SYNC;
            sync_position_next = (byte_count < OFS_MAX) ? byte_count + 1'b1 : OFS_MAX;
          end else begin
            phase_next = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        if (b != (KEY_B + {5'd0, key_index})) header_match_next = 1'b0;
        key_index_next = key_index + 3'd1;
        phase_next     = PH_LENHI;
      end
      PH_SYNC: begin
        if (b != sync_byte(sync_idx)) begin
          emit   = 1'b1;
          status = STATUS_BAD_SYNC;
        end else if (sync_idx == 3'd7) begin
          emit   = 1'b1;
          status = STATUS_OK_HEADER;
          start  = PAYLOAD_BITS'(sync_position);
        end else begin
          field_remaining_next = {13'd0, sync_idx + 3'd1};
        end
      end
      default: ;
    endcase

    byte_count_next = (byte_count < OFS_MAX) ? byte_count + 1'b1 : OFS_MAX;

    if (emit) begin
      verdict_given_next = 1'b1;
      phase_next         = PH_DONE;
    end else if (in_item.last_byte && !verdict_given) begin
      emit   = 1'b1;
      status = STATUS_TOO_SHORT;
      start  = '0;
    end

    // The final byte of a file returns the parser to its reset state.
    if (in_item.last_byte) begin
      phase_next           = PH_PRE;
      byte_count_next      = '0;
      field_remaining_next = '0;
      key_index_next       = '0;
      header_match_next    = 1'b1;
      sync_match_next      = 1'b1;
      verdict_given_next   = 1'b0;
      sync_position_next   = '0;
    end

    result.status        = status;
    result.payload_start = start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_PRE;
      byte_count      <= '0;
      field_remaining <= '0;
      key_index       <= '0;
      header_match    <= 1'b1;
      sync_match      <= 1'b1;
      verdict_given   <= 1'b0;
      sync_position   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      field_remaining <= field_remaining_next;
      key_index       <= key_index_next;
      header_match    <= header_match_next;
      sync_match      <= sync_match_next;
      verdict_given   <= verdict_given_next;
      sync_position   <= sync_position_next;
    end
  end

`ifndef SYNTHESIS
  a_done_iff_verdict: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) == verdict_given)
    else $error("done phase and verdict flag disagree");

  a_key_bound: assert property (@(posedge clk) disable iff (rst)
    key_index <= 3'd4)
    else $error("key index ran past key e");

  a_ok_header_from_sync: assert property (@(posedge clk) disable iff (rst)
    step && emit && (result.status == STATUS_OK_HEADER) |-> phase == PH_SYNC)
    else $error("header verdict outside the sync phase");

  a_no_verdict_after_done: assert property (@(posedge clk) disable iff (rst)
    step && emit && (phase == PH_DONE) |-> 1'b0)
    else $error("second verdict for one file");
`endif

endmodule

[src/bitstream_file_header_parser.sv]
// A byte transfer is registered in the input register and parsed from there;
// its verdict is registered in the result register once that register has space.
// Throughput: one byte per cycle, limited only by stalls on the result side.
// Reset: synchronous, active high; it empties both registers and returns the
// parser to the preamble phase with its counters at zero.
module bitstream_file_header_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  bfhp_pkg::bfhp_in_t  byte_item,
  output logic                result_valid,
  input  logic                result_stall,
  output bfhp_pkg::bfhp_out_t result_item
);
  import bfhp_pkg::*;

  // Input register: holds one byte until the parser can step on it.
  logic      hold_valid;
  bfhp_in_t  hold_item;

  // The parser steps whenever a byte is held and the result register is free or
  // is emptied by a transfer in this same cycle. Every byte waits for that space,
  // whether or not it ends up producing a verdict, which keeps order trivially.
  logic      step;
  logic      emit;
  bfhp_out_t verdict;
  logic      out_free;

  assign out_free   = !result_valid || !result_stall;
  assign step       = hold_valid && out_free;

  // A new byte can enter when the holding register is empty or drains this cycle.
  assign byte_stall = hold_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      hold_item <= byte_item;
    end
  end

  bfhp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_item (hold_item),
    .emit    (emit),
    .result  (verdict)
  );

  // Result register: loads a verdict when the parser emits one and keeps it
  // until the downstream side completes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result_item <= verdict;
    end
  end

`ifndef SYNTHESIS
  a_held_byte_stays: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !step |=> hold_valid && $stable(hold_item))
    else $error("held byte lost before the parser took it");

  a_step_needs_space: assert property (@(posedge clk) disable iff (rst)
    step |-> !(result_valid && result_stall))
    else $error("parser stepped into a full result register");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.status <= STATUS_BAD_SYNC)
    else $error("undefined status code");
`endif

endmodule

[tb/bitstream_file_header_parser_tb.sv]
module bitstream_file_header_parser_tb;
  import bfhp_pkg::*;

  // Run shape. Random files keep coming until both the byte count and the
  // verdict count below are reached.
  localparam int RANDOM_BYTES   = 600;
  localparam int MIN_VERDICTS   = 20;
  // The result side refuses transfers for this many cycles once per run.
  localparam int SQUEEZE_CYCLES = 300;
  // No transfer on either side for this long means the block has hung.
  localparam int QUIET_LIMIT    = 1000;
  // Cycles allowed after the last verdict for any stray result to show up.
  localparam int DRAIN_CYCLES   = 8;

  // Bit-file preamble, bytes 0 to 13, ending in key 'a', and the sync words.
  localparam logic [14*8-1:0] BIT_PREAMBLE = 112'h00_09_0F_F0_0F_F0_0F_F0_0F_F0_00_00_01_61;
  localparam logic [8*8-1:0]  SYNC_WORDS   = 64'hFF_FF_FF_FF_AA_99_55_66;

  // Phases of the byte parser as the predictor tracks them.
  typedef enum logic [3:0] {
    PH_PREAMBLE, PH_HEADERLESS, PH_KEY_A, PH_LEN_HI, PH_LEN_LO,
    PH_SKIP, PH_KEY, PH_SYNC, PH_DONE
  } parse_phase_e;

  // One row of the directed table. When typed is set, the verdict for this
  // byte is written into the row rather than taken from the predictor.
  typedef struct packed {
    logic [7:0]              data;
    logic                    last;
    logic                    typed;
    logic [2:0]              status;
    logic [PAYLOAD_BITS-1:0] start;
  } probe_t;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  bfhp_in_t  byte_item;
  logic      result_valid;
  logic      result_stall;
  bfhp_out_t result_item;

  bitstream_file_header_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // Predictor state: a private copy of everything the parser remembers
  // between bytes of one file.
  logic [OFFSET_BITS-1:0] m_offset;
  parse_phase_e           m_phase;
  logic [15:0]            m_field_left;
  logic [2:0]             m_keys_seen;
  logic                   m_hdr_ok;
  logic                   m_sync_ok;
  logic                   m_decided;
  logic [OFFSET_BITS-1:0] m_sync_at;

  // Verdicts predicted but not yet seen on the result side, oldest first.
  bfhp_out_t   verdict_q [$];
  // The file being sent in the random part.
  logic [7:0]  file_q [$];

  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned verdicts_due;
  int unsigned verdicts_checked;
  int unsigned quiet_cycles = 0;
  int unsigned send_run;
  bit          send_calm;
  logic        squeeze_req;

  // Directed files: a one-byte file, a headerless file with good sync words
  // at offset 0 and one trailing byte after its verdict, and a bit file that
  // stops inside its preamble. Between them every data bit and both values of
  // the last-byte flag are exercised.
  probe_t directed_rows [23] = '{
    '{8'hFF, 1'b1, 1'b1, STATUS_TOO_SHORT, 24'd0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'hAA, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h99, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h55, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h66, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h00, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h7F, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h01, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'hFE, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h00, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h55, 1'b0, 1'b1, STATUS_OK_NO_HDR, 24'd0},
    '{8'hFF, 1'b1, 1'b0, 3'd0, 24'd0},
    '{8'h00, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h09, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h0F, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'hF0, 1'b0, 1'b0, 3'd0, 24'd0},
    '{8'h0F, 1'b1, 1'b1, STATUS_TOO_SHORT, 24'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] preamble_byte(input int unsigned idx);
    return BIT_PREAMBLE[(13 - idx) * 8 +: 8];
  endfunction

  function automatic logic [7:0] sync_word_byte(input int unsigned idx);
    return SYNC_WORDS[(7 - idx) * 8 +: 8];
  endfunction

  // Both sides idle in stretches: a run of items either goes back to back
  // or has a fresh random gap, possibly empty, before each item.
  function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // A new file starts from the same state as after reset.
  task automatic clear_parser();
    m_offset     = '0;
    m_phase      = PH_PREAMBLE;
    m_field_left = '0;
    m_keys_seen  = '0;
    m_hdr_ok     = 1'b1;
    m_sync_ok    = 1'b1;
    m_decided    = 1'b0;
    m_sync_at    = '0;
  endtask

  // Advances the predictor by one byte and says whether that byte yields a
  // verdict, and which.
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output logic emit, output bfhp_out_t res);
    logic [OFFSET_BITS-1:0] pos;
    logic [2:0]             idx;
    pos  = m_offset;
    emit = 1'b0;
    res  = '0;
    case (m_phase)
      PH_PREAMBLE: begin
        // The first bytes are checked against both the bit-file preamble
        // and the sync words, since either kind of file may be arriving.
        if (pos < 14 && b != preamble_byte(pos)) m_hdr_ok = 1'b0;
        if (pos < 8 && b != sync_word_byte(pos)) m_sync_ok = 1'b0;
        if (pos >= 9) m_phase = m_hdr_ok ? PH_KEY_A : PH_HEADERLESS;
      end
      PH_HEADERLESS: begin
        // A file without a preamble gets its verdict at the sixteenth byte.
        if (pos >= 15) begin
          emit = 1'b1;
          res.status = m_sync_ok ? STATUS_OK_NO_HDR : STATUS_BAD_SYNC;
        end
      end
      PH_KEY_A: begin
        // A bad byte in the key 'a' word is only reported at byte 15.
        if (pos < 14 && b != preamble_byte(pos)) m_hdr_ok = 1'b0;
        if (pos >= 13) begin
          m_keys_seen = '0;
          m_phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        if (!m_hdr_ok && pos >= 15) begin
          emit = 1'b1;
          res.status = STATUS_BAD_HEADER;
        end else if (m_keys_seen >= 4) begin
          // The 'e' length is four bytes whose value does not matter.
          m_field_left = 16'd3;
          m_phase = PH_SKIP;
        end else begin
          m_field_left = {b, 8'h00};
          m_phase = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (!m_hdr_ok && pos >= 15) begin
          emit = 1'b1;
          res.status = STATUS_BAD_HEADER;
        end else begin
          m_field_left[7:0] = b;
          // An empty field is followed by its key straight away.
          m_phase = (m_field_left != 16'd0) ? PH_SKIP : PH_KEY;
        end
      end
      PH_SKIP: begin
        if (m_field_left != 16'd0) m_field_left = m_field_left - 16'd1;
        if (m_field_left == 16'd0) begin
          if (m_keys_seen >= 4) begin
            m_phase = PH_SYNC;
            m_sync_at = (pos != OFS_MAX) ? pos + 1'b1 : OFS_MAX;
          end else begin
            m_phase = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        // A wrong key is noticed here but reported on the following byte.
        if (b != KEY_B + 8'(m_keys_seen)) m_hdr_ok = 1'b0;
        m_keys_seen = m_keys_seen + 3'd1;
        m_phase = PH_LEN_HI;
      end
      PH_SYNC: begin
        // During sync the field counter holds the index of the next sync byte.
        idx = m_field_left[2:0];
        if (b != sync_word_byte(idx)) begin
          emit = 1'b1;
          res.status = STATUS_BAD_SYNC;
        end else if (idx == 3'd7) begin
          emit = 1'b1;
          res.status = STATUS_OK_HEADER;
          res.payload_start = m_sync_at[PAYLOAD_BITS-1:0];
        end else begin
          m_field_left = 16'(idx) + 16'd1;
        end
      end
      default: ;
    endcase

    if (m_offset != OFS_MAX) m_offset = m_offset + 1'b1;

    // Once a file has its verdict, the rest of it is ignored; a file that
    // ends with no verdict yet is too short.
    if (emit) begin
      m_decided = 1'b1;
      m_phase = PH_DONE;
    end else if (last && !m_decided) begin
      emit = 1'b1;
      res.status = STATUS_TOO_SHORT;
      res.payload_start = '0;
    end

    if (last) clear_parser();
  endtask

  // Offers one byte, waits for its transfer, then records the verdict it
  // produces. A directed row with a typed verdict must agree with the
  // predictor, and the typed value becomes the expectation.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input bfhp_out_t typed_res);
    int unsigned gap;
    logic        emit;
    bfhp_out_t   res;
    gap = draw_gap(send_run, send_calm);
    // Valid is lowered only when a gap really follows, so that a
    // back-to-back item never sees valid dropped and raised in one step.
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_item  <= '{data_byte: b, last_byte: last};
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);

    parse_byte(b, last, emit, res);
    bytes_sent++;
    if (last) files_sent++;
    if (typed) begin
      if (!emit || res != typed_res) begin
        $display("%0t: directed byte %0d: expected status %0d start %0d, predicted %0d/%0d",
                 $time, bytes_sent, typed_res.status, typed_res.payload_start,
                 emit ? res.status : 3'd7, res.payload_start);
        errors++;
      end
      verdict_q.push_back(typed_res);
      verdicts_due++;
    end else if (emit) begin
      verdict_q.push_back(res);
      verdicts_due++;
    end
  endtask

  // Builds one random file in file_q. Most files are bit files
  // with random field lengths and contents, half of them with one fault put in:
  // a bad preamble or key 'a' byte, a wrong key, a bad sync byte, an early
  // end or a random byte changed. The rest are headerless files, short files
  // and plain noise.
  task automatic make_file();
    int unsigned kind;
    int unsigned len;
    int unsigned sync_ofs;
    int unsigned flip_at;
    int unsigned cut;
    int unsigned key_pos [4];
    bit          do_flip;
    file_q.delete();
    do_flip = 1'b0;
    flip_at = 0;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      for (int i = 0; i < 14; i++) file_q.push_back(preamble_byte(i));
      for (int f = 0; f < 4; f++) begin
        if (f > 0) begin
          key_pos[f-1] = file_q.size();
          file_q.push_back(KEY_B + 8'(f - 1));
        end
        // Mostly tiny fields; now and then a longer one, which may need the
        // upper length byte.
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 300) : $urandom_range(0, 3);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[7:0]);
        repeat (len) file_q.push_back(8'($urandom));
      end
      key_pos[3] = file_q.size();
      file_q.push_back(KEY_B + 8'd3);
      repeat (4) file_q.push_back(8'($urandom));
      sync_ofs = file_q.size();
      for (int i = 0; i < 8; i++) file_q.push_back(sync_word_byte(i));
      repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom));
      case ($urandom_range(0, 9))
        5: begin
          do_flip = 1'b1;
          flip_at = $urandom_range(0, 13);
        end
        6: begin
          do_flip = 1'b1;
          flip_at = key_pos[$urandom_range(0, 3)];
        end
        7: begin
          do_flip = 1'b1;
          flip_at = sync_ofs + $urandom_range(0, 7);
        end
        8: begin
          cut = $urandom_range(1, file_q.size() - 1);
          while (file_q.size() > cut) void'(file_q.pop_back());
        end
        9: begin
          do_flip = 1'b1;
          flip_at = $urandom_range(0, file_q.size() - 1);
        end
        default: ;
      endcase
    end else if (kind < 70) begin
      // Headerless file: sync words at offset 0, enough bytes to reach the
      // verdict, and in a third of them one sync byte spoiled.
      for (int i = 0; i < 8; i++) file_q.push_back(sync_word_byte(i));
      repeat ($urandom_range(8, 20)) file_q.push_back(8'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        do_flip = 1'b1;
        flip_at = $urandom_range(0, 7);
      end
    end else if (kind < 85) begin
      // Short file, cut off before any verdict is possible.
      len = $urandom_range(1, 15);
      case ($urandom_range(0, 2))
        0: for (int i = 0; i < len; i++)
             file_q.push_back(i < 14 ? preamble_byte(i) : 8'($urandom));
        1: for (int i = 0; i < len; i++)
             file_q.push_back(i < 8 ? sync_word_byte(i) : 8'($urandom));
        default: repeat (len) file_q.push_back(8'($urandom));
      endcase
    end else begin
      repeat ($urandom_range(1, 40)) file_q.push_back(8'($urandom));
    end
    if (do_flip) file_q[flip_at] = file_q[flip_at] ^ 8'($urandom_range(1, 255));
  endtask

  // Compares one result transfer with the oldest predicted verdict.
  task automatic check_verdict(input bfhp_out_t got);
    bfhp_out_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t: result with no verdict pending: status %0d start %0d",
               $time, got.status, got.payload_start);
      errors++;
    end else begin
      want = verdict_q.pop_front();
      verdicts_checked++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.payload_start !== want.payload_start) begin
        $display("%0t: payload_start mismatch: expected %0d, got %0d",
                 $time, want.payload_start, got.payload_start);
        errors++;
      end
    end
  endtask

  // Result side. After each transfer it draws a random stall from draw_gap.
  // When the sender asks for it, it refuses results for a long stretch, so
  // that the block's result and input registers fill and the byte side
  // stalls.
  initial begin : result_side
    int unsigned hold_left;
    int unsigned run_left;
    bit          calm;
    bit          squeeze_seen;
    hold_left = 0;
    run_left = 0;
    calm = 1'b0;
    squeeze_seen = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_valid && !result_stall) begin
          check_verdict(result_item);
          hold_left = draw_gap(run_left, calm);
        end
        if (squeeze_req && !squeeze_seen) begin
          squeeze_seen = 1'b1;
          hold_left = SQUEEZE_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          result_stall <= 1'b1;
        end else begin
          result_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either side means
  // the block has stopped, and the run ends as a failure.
  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d verdicts still pending",
               $time, quiet_cycles, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Byte side: reset, the directed files, then random files until enough
  // bytes and verdicts have gone through, then drain and report.
  initial begin : byte_side
    errors = 0;
    bytes_sent = 0;
    files_sent = 0;
    verdicts_due = 0;
    verdicts_checked = 0;
    send_run = 0;
    send_calm = 1'b0;
    clear_parser();
    rst <= 1'b1;
    byte_valid <= 1'b0;
    byte_item <= '0;
    squeeze_req <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                '{status: directed_rows[i].status, payload_start: directed_rows[i].start});

    while (bytes_sent < RANDOM_BYTES || verdicts_due < MIN_VERDICTS) begin
      // A few files in, a burst of one-byte files is sent while the result
      // side holds off. Each of them yields a verdict, so the block fills.
      if (!squeeze_req && files_sent >= 3) begin
        squeeze_req <= 1'b1;
        repeat (12) send_byte(8'($urandom), 1'b1, 1'b0, '0);
      end
      make_file();
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1, 1'b0, '0);
    end
    byte_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d files with random gaps and one long result stall.",
             bytes_sent, files_sent);
    $display("Compared %0d verdicts, %0d mismatches.", verdicts_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[bitstream_file_header_parser.f]
src/bfhp_pkg.sv
src/bfhp_parser.sv
src/bitstream_file_header_parser.sv
tb/bitstream_file_header_parser_tb.sv
